### sv/label_mode_filter_2d_assert.svh
// Assertion macros for the label mode filter.
// Included by modules that check their own control logic; uses clk_i and rst_ni.
`ifndef LABEL_MODE_FILTER_2D_ASSERT_SVH
`define LABEL_MODE_FILTER_2D_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define LMF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies a consequence on the next edge.
`define LMF_ASSERT_NEXT(name, cond, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) \
    else $error(msg);

`endif

### sv/lmf_pkg.sv
// Shared types and constants for the label mode filter.
// No dependencies.
package lmf_pkg;

  localparam int ROW_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SCAN,
    ST_DRAIN,
    ST_WRITE,
    ST_EMIT
  } lmf_state_e;

  // Commands from the sequencer to the tally table
  typedef struct packed {
    logic clear;
    logic upd;
  } lmf_tally_ctrl_t;

endpackage

### sv/label_mode_filter_2d.sv
// Label mode filter top level: sequencer, position counters, config registers.
// Depends on lmf_pkg, lmf_line_mem, lmf_tally and the assertion header.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+------------------------------
//  input    | in        | in_valid_i/in_stall_o | pixel_label_i, flush_i
//  output   | out       | out_valid_o/out_stall_i | mode_label_o, frame_last_o
//  config   | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// An item with no result steps through accept, evaluate and store write.
// An item with a result adds a window scan (up to 49 pixels at half size 3) with
// one line-buffer read and one tally update per cycle, then a drain and an emit.
// Reset clears the position counters and control; line buffers need no clearing.
// A stalled output holds its register; the next item is taken meanwhile and
// waits before the output stage only if it also has a result.
module label_mode_filter_2d
  import lmf_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HALF = 3,
  parameter int LABEL_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [31:0]           pixel_label_i,
  input  logic                  flush_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [31:0]           mode_label_o,
  output logic                  frame_last_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

`include "label_mode_filter_2d_assert.svh"

  localparam int RING = 2 * MAX_HALF + 1;
  localparam int TALLY = RING * RING;
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RGW = $clog2(RING);
  localparam int KW = $clog2(MAX_HALF + 1);

  lmf_state_e state_q, state_d;

  logic [1:0]       half_q;
  logic [10:0]      width_q;
  logic [ROW_W-1:0] height_q;

  logic [CW-1:0]    in_col_q, out_col_q;
  logic [ROW_W-1:0] in_row_q, out_row_q;
  logic [RGW-1:0]   in_ring_q, out_ring_q;

  logic [LABEL_BITS-1:0] label_q;
  logic                  take_q;
  logic [CW-1:0]         pc_q;
  logic [ROW_W-1:0]      pr_q;
  logic [RGW-1:0]        pring_q;
  logic                  has_res_q;

  logic [ROW_W-1:0] scan_r_q, r1_q;
  logic [CW-1:0]    scan_c_q, c0_q, c1_q;
  logic [RGW-1:0]   scan_ring_q;
  logic             rd_v_q, byp_q;

  logic [31:0] out_label_q;
  logic        out_last_q, out_valid_q;

  logic [WW-1:0]    w_eff;
  logic [ROW_W-1:0] h_eff;
  logic [KW-1:0]    k_eff;
  logic [ROW_W:0]   kk;

  logic [ROW_W:0]   orow_k;
  logic [ROW_W-1:0] nr, r0, r1;
  logic [WW:0]      ocol_k;
  logic [CW-1:0]    nc, c0, c1;
  logic             ready;
  logic [KW-1:0]    dr;
  logic [RGW:0]     ring0;

  logic             take;
  logic [WW-1:0]    in_col_inc;
  logic             out_free, emit_fire, last, cfg_hit;

  lmf_tally_ctrl_t       tctrl;
  logic [LABEL_BITS-1:0] rd_data, tally_label, best;

  // Effective image size and half size
  always_comb begin
    if (width_q == '0) w_eff = WW'(1);
    else if (32'(width_q) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(width_q);
    h_eff = (height_q == '0) ? ROW_W'(1) : height_q;
    kk = (ROW_W + 1)'(half_q);
    if (kk > (ROW_W + 1)'(MAX_HALF)) kk = (ROW_W + 1)'(MAX_HALF);
    if (kk > (ROW_W + 1)'(w_eff >> 1)) kk = (ROW_W + 1)'(w_eff >> 1);
    if (kk > (ROW_W + 1)'(h_eff >> 1)) kk = (ROW_W + 1)'(h_eff >> 1);
    k_eff = KW'(kk);
  end

  // Window bounds and readiness of the next output
  always_comb begin
    orow_k = (ROW_W + 1)'(out_row_q) + (ROW_W + 1)'(k_eff);
    nr = (orow_k > (ROW_W + 1)'(h_eff - ROW_W'(1))) ? h_eff - ROW_W'(1) : orow_k[ROW_W-1:0];
    r1 = nr;
    r0 = (out_row_q >= ROW_W'(k_eff)) ? out_row_q - ROW_W'(k_eff) : '0;
    ocol_k = (WW + 1)'(out_col_q) + (WW + 1)'(k_eff);
    nc = (ocol_k > (WW + 1)'(w_eff - WW'(1))) ? CW'(w_eff - WW'(1)) : CW'(ocol_k);
    c1 = nc;
    c0 = (out_col_q >= CW'(k_eff)) ? out_col_q - CW'(k_eff) : '0;
    ready = (in_row_q >= h_eff) || (nr < in_row_q) || ((nr == in_row_q) && (nc < in_col_q));
    dr = KW'(out_row_q - r0);
    if ((RGW + 1)'(out_ring_q) >= (RGW + 1)'(dr))
      ring0 = (RGW + 1)'(out_ring_q) - (RGW + 1)'(dr);
    else
      ring0 = (RGW + 1)'(out_ring_q) + (RGW + 1)'(RING) - (RGW + 1)'(dr);
  end

  assign take       = !flush_i && (in_row_q < h_eff);
  assign in_col_inc = WW'(in_col_q) + WW'(1);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign emit_fire  = (state_q == ST_EMIT) && out_free;
  assign last       = (out_row_q == h_eff - ROW_W'(1)) && (WW'(out_col_q) == w_eff - WW'(1));
  assign cfg_ready_o = 1'b1;
  assign cfg_hit = cfg_valid_i && (cfg_index_i == CFG_HALF_SIZE || cfg_index_i == CFG_WIDTH
                                   || cfg_index_i == CFG_HEIGHT);

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and unit control
  always_comb begin
    state_d = state_q;
    tctrl = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (ready) begin
          tctrl.clear = 1'b1;
          state_d = ST_SCAN;
        end else begin
          state_d = ST_WRITE;
        end
      end
      ST_SCAN: begin
        tctrl.upd = rd_v_q;
        if (scan_c_q == c1_q && scan_r_q == r1_q) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        tctrl.upd = rd_v_q;
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        state_d = has_res_q ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Configuration registers and position counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q     <= 2'd1;
      width_q    <= 11'd1024;
      height_q   <= 16'd1024;
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_ring_q  <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_ring_q <= '0;
      has_res_q  <= 1'b0;
      take_q     <= 1'b0;
      rd_v_q     <= 1'b0;
    end else begin
      rd_v_q <= (state_q == ST_SCAN);
      // Accept a transaction and advance the input position
      if (state_q == ST_IDLE && in_valid_i) begin
        take_q <= take;
        if (take) begin
          if (in_col_inc >= w_eff) begin
            in_col_q  <= '0;
            in_row_q  <= in_row_q + ROW_W'(1);
            in_ring_q <= (in_ring_q == RGW'(RING - 1)) ? '0 : in_ring_q + RGW'(1);
          end else begin
            in_col_q <= CW'(in_col_inc);
          end
        end
      end
      if (state_q == ST_EVAL) has_res_q <= ready;
      // Advance the output position, restart after the final pixel
      if (emit_fire) begin
        if (last) begin
          in_col_q   <= '0;
          in_row_q   <= '0;
          in_ring_q  <= '0;
          out_col_q  <= '0;
          out_row_q  <= '0;
          out_ring_q <= '0;
        end else if (WW'(out_col_q) + WW'(1) >= w_eff) begin
          out_col_q  <= '0;
          out_row_q  <= out_row_q + ROW_W'(1);
          out_ring_q <= (out_ring_q == RGW'(RING - 1)) ? '0 : out_ring_q + RGW'(1);
        end else begin
          out_col_q <= out_col_q + CW'(1);
        end
      end
      // Register write starts a new image
      if (cfg_hit) begin
        unique case (cfg_index_i)
          CFG_HALF_SIZE: half_q <= cfg_data_i[1:0];
          CFG_WIDTH:     width_q <= cfg_data_i[10:0];
          CFG_HEIGHT:    height_q <= cfg_data_i;
          default:       half_q <= half_q;
        endcase
        in_col_q   <= '0;
        in_row_q   <= '0;
        in_ring_q  <= '0;
        out_col_q  <= '0;
        out_row_q  <= '0;
        out_ring_q <= '0;
      end
    end
  end

  // Item payload and window scan counters
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      label_q <= pixel_label_i[LABEL_BITS-1:0];
      pc_q    <= in_col_q;
      pr_q    <= in_row_q;
      pring_q <= in_ring_q;
    end
    byp_q <= take_q && (scan_r_q == pr_q) && (scan_c_q == pc_q);
    if (state_q == ST_EVAL) begin
      scan_r_q    <= r0;
      r1_q        <= r1;
      scan_c_q    <= c0;
      c0_q        <= c0;
      c1_q        <= c1;
      scan_ring_q <= RGW'(ring0);
    end else if (state_q == ST_SCAN) begin
      if (scan_c_q == c1_q) begin
        scan_c_q    <= c0_q;
        scan_r_q    <= scan_r_q + ROW_W'(1);
        scan_ring_q <= (scan_ring_q == RGW'(RING - 1)) ? '0 : scan_ring_q + RGW'(1);
      end else begin
        scan_c_q <= scan_c_q + CW'(1);
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      out_label_q <= 32'(best);
      out_last_q  <= last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign mode_label_o = out_label_q;
  assign frame_last_o = out_last_q;

  assign tally_label = byp_q ? label_q : rd_data;

  lmf_line_mem #(
    .RING(RING),
    .MAX_WIDTH(MAX_WIDTH),
    .LABEL_BITS(LABEL_BITS)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (state_q == ST_WRITE && take_q),
    .wr_ring_i (pring_q),
    .wr_col_i  (pc_q),
    .wr_data_i (label_q),
    .rd_en_i   (state_q == ST_SCAN),
    .rd_ring_i (scan_ring_q),
    .rd_col_i  (scan_c_q),
    .rd_data_o (rd_data)
  );

  lmf_tally #(
    .TALLY(TALLY),
    .LABEL_BITS(LABEL_BITS)
  ) u_tally (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (tctrl),
    .label_i (tally_label),
    .best_o  (best)
  );

  // Scan column stays inside the window
  `LMF_ASSERT(a_scan_col, (state_q != ST_SCAN) || (scan_c_q >= c0_q && scan_c_q <= c1_q),
              "scan column left the window")
  // Ring pointers stay inside the ring
  `LMF_ASSERT(a_ring, (in_ring_q < RGW'(RING)) && (out_ring_q < RGW'(RING)),
              "ring pointer out of range")
  // A fired result shows up at the output and the sequencer returns to idle
  `LMF_ASSERT_NEXT(a_emit, emit_fire, out_valid_q && state_q == ST_IDLE,
                   "result not presented after emit")

endmodule

### sv/lmf_line_mem.sv
// Ring of line buffers holding the most recent image rows.
// Depends on nothing; one write and one registered read port.
module lmf_line_mem #(
  parameter int RING = 7,
  parameter int MAX_WIDTH = 1024,
  parameter int LABEL_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          wr_en_i,
  input  logic [$clog2(RING)-1:0]       wr_ring_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]  wr_col_i,
  input  logic [LABEL_BITS-1:0]         wr_data_i,
  input  logic                          rd_en_i,
  input  logic [$clog2(RING)-1:0]       rd_ring_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]  rd_col_i,
  output logic [LABEL_BITS-1:0]         rd_data_o
);

  logic [LABEL_BITS-1:0] mem [RING][MAX_WIDTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_ring_i][wr_col_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_ring_i][rd_col_i];
    end
  end

endmodule

### sv/lmf_tally.sv
// Tally table: parallel label compare with a running best label.
// Depends on lmf_pkg for the control struct.
module lmf_tally
  import lmf_pkg::*;
#(
  parameter int TALLY = 49,
  parameter int LABEL_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lmf_tally_ctrl_t       ctrl_i,
  input  logic [LABEL_BITS-1:0] label_i,
  output logic [LABEL_BITS-1:0] best_o
);

  localparam int IDXW = $clog2(TALLY);
  localparam int CNTW = $clog2(TALLY + 1);

  logic [LABEL_BITS-1:0] labels_q [TALLY];
  logic [CNTW-1:0]       counts_q [TALLY];
  logic [CNTW-1:0]       used_q;
  logic [LABEL_BITS-1:0] best_label_q;
  logic [CNTW-1:0]       best_cnt_q;
  logic [IDXW-1:0]       best_idx_q;

  logic [TALLY-1:0] hit;
  logic             any_hit;
  logic [IDXW-1:0]  hit_idx;
  logic [CNTW-1:0]  hit_cnt;
  logic [IDXW-1:0]  upd_idx;
  logic [CNTW-1:0]  new_cnt;
  logic             better;

  // Compare the label against every live entry and encode the hit
  always_comb begin
    hit_idx = '0;
    hit_cnt = '0;
    for (int i = 0; i < TALLY; i++) begin
      hit[i] = (CNTW'(i) < used_q) && (labels_q[i] == label_i);
      if (hit[i]) begin
        hit_idx = hit_idx | IDXW'(i);
        hit_cnt = hit_cnt | counts_q[i];
      end
    end
    any_hit = |hit;
    upd_idx = any_hit ? hit_idx : used_q[IDXW-1:0];
    new_cnt = any_hit ? hit_cnt + CNTW'(1) : CNTW'(1);
    // Highest count wins; equal counts go to the earlier entry
    better = (new_cnt > best_cnt_q) || ((new_cnt == best_cnt_q) && (upd_idx < best_idx_q));
  end

  // Count control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q     <= '0;
      best_cnt_q <= '0;
      best_idx_q <= '0;
    end else if (ctrl_i.clear) begin
      used_q     <= '0;
      best_cnt_q <= '0;
      best_idx_q <= '0;
    end else if (ctrl_i.upd) begin
      if (!any_hit) begin
        used_q <= used_q + CNTW'(1);
      end
      if (better) begin
        best_cnt_q <= new_cnt;
        best_idx_q <= upd_idx;
      end
    end
  end

  // Table payload
  always_ff @(posedge clk_i) begin
    if (ctrl_i.clear) begin
      best_label_q <= '0;
    end else if (ctrl_i.upd) begin
      labels_q[upd_idx] <= label_i;
      counts_q[upd_idx] <= new_cnt;
      if (better) begin
        best_label_q <= label_i;
      end
    end
  end

  assign best_o = best_label_q;

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for label_mode_filter_2d: random pixel streams, flushes and
// register writes against a behavioral mode-filter predictor. Depends on lmf_pkg.
module tb;
  import lmf_pkg::*;

  localparam int RING = 7;
  localparam int LINE = 1024;
  localparam int WDOG_LIMIT = 20000;

  // Index outside the register list; a write there changes nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct {
    logic [31:0] label;
    logic        flush;
  } pixel_t;

  typedef struct {
    logic [31:0] mode;
    logic        last;
  } mode_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall_o;
  logic [31:0] pixel_label = '0;
  logic flush = 1'b0;
  logic out_valid_o;
  logic out_stall = 1'b0;
  logic [31:0] mode_label_o;
  logic frame_last_o;
  logic cfg_valid = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  label_mode_filter_2d u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall_o),
    .pixel_label_i(pixel_label), .flush_i(flush),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall),
    .mode_label_o(mode_label_o), .frame_last_o(frame_last_o),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Predictor state
  logic [1:0]  half_q = 2'd1;
  logic [10:0] width_q = 11'd1024;
  logic [15:0] height_q = 16'd1024;
  logic [31:0] line_mem [RING*LINE];
  int in_col, in_row, out_col, out_row;

  pixel_t pending_px[$];
  mode_t  mode_q[$];
  int errors = 0;
  int cfg_count = 0;
  bit idle_en = 1'b0;
  int in_gap = 0;
  int out_gap = 0;
  int wdog = 0;

  function automatic int eff_w();
    return (width_q == 0) ? 1 : (width_q > LINE) ? LINE : int'(width_q);
  endfunction

  function automatic int eff_h();
    return (height_q == 0) ? 1 : int'(height_q);
  endfunction

  function automatic int eff_k();
    int k;
    k = half_q;
    if (k > eff_w() / 2) k = eff_w() / 2;
    if (k > eff_h() / 2) k = eff_h() / 2;
    return k;
  endfunction

  // Advance the filter by one transaction; report the mode result if any
  function automatic void filter_step(input logic [31:0] lbl, input logic fl,
                                      output bit got, output mode_t res);
    int w, h, k, pr, pc, nr, nc, r0, r1, c0, c1, used, best_cnt;
    bit take, ready;
    logic [31:0] v;
    logic [31:0] tl [49];
    int tc [49];
    int l;
    w = eff_w();
    h = eff_h();
    k = eff_k();
    take = !fl && in_row < h;
    pr = in_row;
    pc = in_col;
    got = 1'b0;
    res.mode = '0;
    res.last = 1'b0;
    if (take) begin
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
    end
    nr = (out_row + k > h - 1) ? h - 1 : out_row + k;
    nc = (out_col + k > w - 1) ? w - 1 : out_col + k;
    ready = in_row >= h || nr < in_row || (nr == in_row && nc < in_col);
    if (ready) begin
      r0 = (out_row >= k) ? out_row - k : 0;
      r1 = nr;
      c0 = (out_col >= k) ? out_col - k : 0;
      c1 = nc;
      used = 0;
      for (int r = r0; r <= r1; r++) begin
        for (int c = c0; c <= c1; c++) begin
          if (take && r == pr && c == pc) v = lbl;
          else v = line_mem[(r % RING) * LINE + c];
          for (l = 0; l < used; l++) begin
            if (tl[l] == v) begin
              tc[l]++;
              break;
            end
          end
          if (l == used) begin
            tl[used] = v;
            tc[used] = 1;
            used++;
          end
        end
      end
      // Ties keep the label seen first
      best_cnt = 0;
      for (l = 0; l < used; l++) begin
        if (tc[l] > best_cnt) begin
          best_cnt = tc[l];
          res.mode = tl[l];
        end
      end
      res.last = (out_row == h - 1 && out_col == w - 1);
      got = 1'b1;
    end
    if (take) line_mem[(pr % RING) * LINE + pc] = lbl;
    if (got) begin
      if (res.last) begin
        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      end else begin
        out_col++;
        if (out_col >= w) begin
          out_col = 0;
          out_row++;
        end
      end
    end
  endfunction

  // Driver: hold payload while stalled, insert random gaps
  always @(posedge clk_i) begin
    bit got;
    mode_t res;
    pixel_t px;
    if (in_valid && !in_stall_o) begin
      filter_step(pixel_label, flush, got, res);
      if (got) mode_q.push_back(res);
    end
    if (!in_valid || !in_stall_o) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_px.size() > 0) begin
        px = pending_px.pop_front();
        pixel_label <= px.label;
        flush <= px.flush;
        in_valid <= 1'b1;
        if (idle_en && $urandom_range(0, 9) == 0) in_gap <= $urandom_range(1, 19);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: random output stalls and result compare
  always @(posedge clk_i) begin
    mode_t exp_r;
    if (out_valid_o && !out_stall) begin
      if (mode_q.size() == 0) begin
        $display("%0t: unexpected result mode_label=%h frame_last=%b",
                 $time, mode_label_o, frame_last_o);
        errors++;
      end else begin
        exp_r = mode_q.pop_front();
        if (mode_label_o !== exp_r.mode) begin
          $display("%0t: mode_label expected %h actual %h", $time, exp_r.mode, mode_label_o);
          errors++;
        end
        if (frame_last_o !== exp_r.last) begin
          $display("%0t: frame_last expected %b actual %b", $time, exp_r.last, frame_last_o);
          errors++;
        end
      end
    end
    if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_stall <= 1'b1;
    end else if (idle_en && $urandom_range(0, 9) == 0) begin
      out_gap <= $urandom_range(0, 18);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Register writes: update the predictor and drop valid on acceptance
  always @(posedge clk_i) begin
    if (cfg_valid && cfg_ready_o) begin
      case (cfg_index)
        CFG_HALF_SIZE: half_q <= cfg_data[1:0];
        CFG_WIDTH:     width_q <= cfg_data[10:0];
        CFG_HEIGHT:    height_q <= cfg_data[15:0];
        default: ;
      endcase
      if (cfg_index != CFG_SPARE) begin
        in_col <= 0; in_row <= 0; out_col <= 0; out_row <= 0;
      end
      cfg_valid <= 1'b0;
      cfg_count <= cfg_count + 1;
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall) || (cfg_valid && cfg_ready_o))
      wdog <= 0;
    else if (wdog >= WDOG_LIMIT) begin
      $display("FAIL label_mode_filter_2d");
      $finish;
    end else
      wdog <= wdog + 1;
  end

  task automatic wait_idle();
    while (pending_px.size() != 0 || in_valid || mode_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    int target;
    target = cfg_count + 1;
    @(posedge clk_i);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    while (cfg_count != target) @(posedge clk_i);
  endtask

  task automatic set_frame(input int hs, input int w, input int h);
    wait_idle();
    write_reg(CFG_HALF_SIZE, CFG_DATA_W'(hs) | (CFG_DATA_W'($urandom) & 16'hFFFC));
    write_reg(CFG_WIDTH, CFG_DATA_W'(w) | (CFG_DATA_W'($urandom) & 16'hF800));
    write_reg(CFG_HEIGHT, CFG_DATA_W'(h));
  endtask

  function automatic void push_px(input logic [31:0] lbl, input logic fl);
    pixel_t px;
    px.label = lbl;
    px.flush = fl;
    pending_px.push_back(px);
  endfunction

  // Stream one image, with noise flushes if noisy, then drain if it is complete
  task automatic send_image(input int npix, input bit noisy, inout int sent);
    logic [31:0] pal [4];
    int drain;
    foreach (pal[i]) pal[i] = $urandom;
    for (int i = 0; i < npix; i++) begin
      if (noisy && $urandom_range(0, 19) == 0) begin
        push_px($urandom, 1'b1);
        sent++;
      end
      push_px(($urandom_range(0, 9) == 0) ? $urandom : pal[$urandom_range(0, 3)], 1'b0);
      sent++;
    end
    if (npix == eff_w() * eff_h()) begin
      drain = eff_k() * eff_w() + eff_k() + (noisy ? $urandom_range(0, 2) : 0);
      for (int i = 0; i < drain; i++) begin
        // A pixel after the image is complete acts as a drain
        push_px($urandom, (noisy && $urandom_range(0, 5) == 0) ? 1'b0 : 1'b1);
        sent++;
      end
    end
  endtask

  initial begin
    int sent, w, h, npix;
    sent = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    idle_en = 1'b1;

    // Directed: 3x3 image with ties, extreme labels, flush with a label
    set_frame(1, 3, 3);
    push_px(32'h0000_0000, 1'b0);
    push_px(32'hFFFF_FFFF, 1'b0);
    push_px(32'hFFFF_FFFF, 1'b0);
    push_px(32'h0000_0000, 1'b0);
    push_px(32'hDEAD_BEEF, 1'b1);
    push_px(32'h5555_5555, 1'b0);
    push_px(32'hAAAA_AAAA, 1'b0);
    push_px(32'h0000_0000, 1'b0);
    push_px(32'hFFFF_FFFF, 1'b0);
    push_px(32'h1234_5678, 1'b0);
    for (int i = 0; i < 4; i++) push_px(32'h0, 1'b1);
    push_px(32'h0, 1'b1);
    // Zero width and height act as a single pixel
    set_frame(3, 0, 0);
    push_px(32'h8000_0001, 1'b0);
    push_px(32'h7FFF_FFFE, 1'b0);
    // Largest sizes: a few pixels, then a register write starts over
    set_frame(3, 2047, 65535);
    for (int i = 0; i < 3; i++) push_px($urandom, 1'b0);
    wait_idle();
    write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
    set_frame(2, 1024, 2);
    for (int i = 0; i < 3; i++) push_px($urandom, 1'b0);

    // Random images, mostly complete and small
    while (sent < 1700) begin
      if ($urandom_range(0, 3) == 0) idle_en = 1'b0;
      else idle_en = 1'b1;
      if (sent > 1450) idle_en = 1'b0;
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      h = $urandom_range(1, 10);
      set_frame($urandom_range(0, 3), w, h);
      npix = w * h;
      if ($urandom_range(0, 7) == 0) npix = $urandom_range(0, npix);
      send_image(npix, $urandom_range(0, 2) != 0, sent);
    end

    wait_idle();
    repeat (100) @(posedge clk_i);
    if (errors == 0) $display("PASS label_mode_filter_2d");
    else $display("FAIL label_mode_filter_2d");
    $finish;
  end
endmodule
